### rtl/bpb_pkg.sv
`default_nettype none

package bpb_pkg;

    // Window and number format
    localparam int WINDOW_MAX = 64;
    localparam int FRAC_BITS  = 16;
    localparam int PRICE_W    = 24;
    localparam int CFG_W      = 7;
    localparam int PB_W       = 20;

    localparam logic [CFG_W-1:0] WINDOW_RESET = CFG_W'(20);

    // Derived widths
    localparam int SLOT_W  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CNT_W   = $clog2(WINDOW_MAX + 1);
    localparam int SQ_W    = 2 * PRICE_W;
    localparam int SUM_W   = PRICE_W + CNT_W;
    localparam int SUMSQ_W = SQ_W + CNT_W;
    localparam int D_W     = SUMSQ_W + CNT_W;     // twice SUM_W, always even
    localparam int RT_W    = D_W / 2;
    localparam int NC_W    = PRICE_W + CNT_W;
    localparam int DIFF_W  = NC_W + 1;
    localparam int MAG_W   = DIFF_W - 1 + FRAC_BITS;
    localparam int DEN_W   = RT_W + 2;
    localparam int QB      = PB_W;                // quotient bits before saturation
    localparam int Q_W     = QB + 2;

    localparam int HALF   = 1 << (FRAC_BITS - 1);
    localparam int PB_MAX = (1 << (PB_W - 1)) - 1;
    localparam int PB_MIN = -(1 << (PB_W - 1));

    localparam int TDATA_IN_W  = ((PRICE_W + 7) / 8) * 8;
    localparam int TDATA_OUT_W = ((PB_W + 7) / 8) * 8;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
        logic [PRICE_W-1:0] data;
    } ring_wr_t;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
    } ring_rd_t;

    typedef struct packed {
        logic           start;
        logic [D_W-1:0] radicand;
    } root_req_t;

    typedef struct packed {
        logic            done;
        logic [RT_W-1:0] root;
    } root_res_t;

    typedef struct packed {
        logic             start;
        logic [MAG_W-1:0] mag;
        logic [DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic          done;
        logic          ovf;
        logic [QB-1:0] quo;
        logic          rem_nz;
    } div_res_t;

endpackage

`default_nettype wire

### rtl/bpb_ring.sv
`default_nettype none

module bpb_ring
    import bpb_pkg::*;
(
    input  wire logic               clk,
    input  wire ring_wr_t           wr,
    input  wire ring_rd_t           rd,
    output logic [PRICE_W-1:0]      rdata
);

    logic [PRICE_W-1:0] mem [WINDOW_MAX];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rdata <= mem[rd.addr];
        end
    end

endmodule

`default_nettype wire

### rtl/bpb_isqrt.sv
`default_nettype none

module bpb_isqrt
    import bpb_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire root_req_t req,
    output root_res_t      res
);

    localparam int ITER_W = $clog2(RT_W + 1);

    logic [D_W-1:0]    rad_reg, rad_next;
    logic [D_W-1:0]    acc_reg, acc_next;
    logic [D_W-1:0]    bit_reg, bit_next;
    logic [D_W-1:0]    trial;
    logic [ITER_W-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    // One result bit per cycle, bit walks down by powers of four
    always_comb
    begin
        rad_next  = rad_reg;
        acc_next  = acc_reg;
        bit_next  = bit_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = acc_reg + bit_reg;
        if (req.start)
        begin
            rad_next  = req.radicand;
            acc_next  = '0;
            bit_next  = D_W'(1) << (D_W - 2);
            cnt_next  = ITER_W'(RT_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (rad_reg >= trial)
            begin
                rad_next = rad_reg - trial;
                acc_next = (acc_reg >> 1) + bit_reg;
            end
            else
            begin
                acc_next = acc_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            cnt_next = cnt_reg - ITER_W'(1);
            if (cnt_reg == ITER_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg <= rad_next;
        acc_reg <= acc_next;
        bit_reg <= bit_next;
    end

    assign res.done = done_reg;
    assign res.root = acc_reg[RT_W-1:0];

endmodule

`default_nettype wire

### rtl/bpb_div.sv
`default_nettype none

module bpb_div
    import bpb_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_req_t req,
    output div_res_t      res
);

    localparam int ITER_W = $clog2(QB + 1);
    localparam int HI_W   = MAG_W - QB;

    logic [DEN_W-1:0]  rem_reg, rem_next;
    logic [DEN_W-1:0]  den_reg, den_next;
    logic [QB-1:0]     low_reg, low_next;
    logic [QB-1:0]     quo_reg, quo_next;
    logic [DEN_W:0]    trial;
    logic [DEN_W-1:0]  hi_part;
    logic [ITER_W-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic              ovf_reg, ovf_next;

    // Restoring division, one quotient bit per cycle; a quotient that
    // needs more than QB bits is flagged at once
    always_comb
    begin
        rem_next  = rem_reg;
        den_next  = den_reg;
        low_next  = low_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        ovf_next  = ovf_reg;
        done_next = 1'b0;
        hi_part   = DEN_W'(req.mag[MAG_W-1 -: HI_W]);
        trial     = {rem_reg, low_reg[QB-1]};
        if (req.start)
        begin
            den_next = req.den;
            rem_next = hi_part;
            low_next = req.mag[QB-1:0];
            quo_next = '0;
            cnt_next = ITER_W'(QB);
            if (hi_part >= req.den)
            begin
                ovf_next  = 1'b1;
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                ovf_next  = 1'b0;
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = DEN_W'(trial - {1'b0, den_reg});
                quo_next = {quo_reg[QB-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DEN_W-1:0];
                quo_next = {quo_reg[QB-2:0], 1'b0};
            end
            low_next = low_reg << 1;
            cnt_next = cnt_reg - ITER_W'(1);
            if (cnt_reg == ITER_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            ovf_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
            ovf_reg  <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        low_reg <= low_next;
        quo_reg <= quo_next;
    end

    assign res.done   = done_reg;
    assign res.ovf    = ovf_reg;
    assign res.quo    = quo_reg;
    assign res.rem_nz = (rem_reg != '0);

endmodule

`default_nettype wire

### rtl/bollinger_percent_b.sv
// Bollinger band %B (band width 2) over the last N closing prices.
//
// Input stream (s_*): one closing price per item in s_tdata, s_tuser marks the
// first price of a new series and clears the fill count before it is stored.
// Output stream (m_*): one result item per input item, signed Q.16 %B in
// m_tdata and the window_full / flat_window / clipped flags in m_tuser.
// Config channel (cfg_*): window length N, always ready; write it only while
// no item is in flight. Reset value is 20.
//
// Each item is stored in a 64 entry price memory, then the last N entries are
// read back one per cycle for the sum and sum of squares. N*sumsq comes from
// shift-add, the root from a bit-serial square root and the quotient from a
// bit-serial divider, which a flat window skips. A window not yet full goes
// straight from acceptance to the result. Items go one at a time.
//
// Reset clears the fill count, write slot and all control state; the price
// memory holds no reset value and is only read where it was written. A stalled
// receiver holds the result in the output register; the next item may be
// accepted meanwhile, and its result waits until the register frees up.

`default_nettype none

module bollinger_percent_b
    import bpb_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [TDATA_IN_W-1:0]  s_tdata,   // [23:0] close_price
    input  wire logic                   s_tuser,   // [0] start_series

    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [TDATA_OUT_W-1:0]      m_tdata,   // [19:0] percent_b, rest zero
    output logic [2:0]                  m_tuser,   // [0] window_full, [1] flat_window,
                                                   // [2] clipped

    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_W-1:0]       cfg_data   // window_length
);

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_ACC  = 7'b0000010,
        ST_MUL  = 7'b0000100,
        ST_DIFF = 7'b0001000,
        ST_ROOT = 7'b0010000,
        ST_DIV  = 7'b0100000,
        ST_DONE = 7'b1000000
    } state_t;

    state_t               state_reg, state_next;
    logic [CFG_W-1:0]     wl_reg;
    logic [SLOT_W-1:0]    slot_reg, slot_next;
    logic [CNT_W-1:0]     fill_reg, fill_next;
    logic [CNT_W-1:0]     fill_base;
    logic [CNT_W-1:0]     n_clamp;

    logic [PRICE_W-1:0]   close_reg, close_next;
    logic [CNT_W-1:0]     n_reg, n_next;
    logic [SLOT_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]     issue_reg, issue_next;
    logic                 v1_reg, v1_next;
    logic                 v2_reg, v2_next;
    logic [SQ_W-1:0]      sq_reg, sq_next;
    logic [SUM_W-1:0]     sum_reg, sum_next;
    logic [SUMSQ_W-1:0]   sumsq_reg, sumsq_next;
    logic [D_W-1:0]       mcand_reg, mcand_next;
    logic [CNT_W-1:0]     mplier_reg, mplier_next;
    logic [D_W-1:0]       nq_reg, nq_next;
    logic [D_W-1:0]       ss_reg, ss_next;
    logic [DIFF_W-1:0]    diff_reg, diff_next;
    logic [NC_W-1:0]      n_close;

    logic [PB_W-1:0]      res_pb_reg, res_pb_next;
    logic                 res_full_reg, res_full_next;
    logic                 res_flat_reg, res_flat_next;
    logic                 res_clip_reg, res_clip_next;

    logic                 out_valid_reg, out_valid_next;
    logic [PB_W-1:0]      out_pb_reg, out_pb_next;
    logic                 out_full_reg, out_full_next;
    logic                 out_flat_reg, out_flat_next;
    logic                 out_clip_reg, out_clip_next;

    logic                 in_fire;
    logic                 issue_en;
    logic                 out_load;
    logic                 diff_neg;
    logic [DIFF_W-2:0]    diff_mag;
    logic [DIFF_W-1:0]    diff_abs;
    logic [Q_W-1:0]       q_mag;
    logic [Q_W-1:0]       q_val;
    logic [Q_W-1:0]       pb_sum;

    ring_wr_t             ring_wr;
    ring_rd_t             ring_rd;
    logic [PRICE_W-1:0]   ring_rdata;
    root_req_t            root_req;
    root_res_t            root_res;
    div_req_t             div_req;
    div_res_t             div_res;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_fire   = s_tvalid && s_tready;
    assign issue_en  = (state_reg == ST_ACC) && (issue_reg != n_reg);
    assign out_load  = (state_reg == ST_DONE) && (!out_valid_reg || m_tready);

    // Store every accepted price at the write slot
    assign ring_wr.en   = in_fire;
    assign ring_wr.addr = slot_reg;
    assign ring_wr.data = s_tdata[PRICE_W-1:0];

    // Walk back from the newest price, one entry per cycle
    assign ring_rd.en   = issue_en;
    assign ring_rd.addr = rd_ptr_reg;

    bpb_ring u_ring (
        .clk   (clk),
        .wr    (ring_wr),
        .rd    (ring_rd),
        .rdata (ring_rdata)
    );

    assign root_req.start    = (state_reg == ST_DIFF);
    assign root_req.radicand = nq_reg - ss_reg;

    bpb_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (root_req),
        .res   (root_res)
    );

    // Divide |N*close - S| * 2^FRAC_BITS by 4*r
    assign diff_neg      = diff_reg[DIFF_W-1];
    assign diff_abs      = diff_neg ? (DIFF_W'(0) - diff_reg) : diff_reg;
    assign diff_mag      = diff_abs[DIFF_W-2:0];
    assign div_req.start = (state_reg == ST_ROOT) && root_res.done && (root_res.root != '0);
    assign div_req.mag   = {diff_mag, {FRAC_BITS{1'b0}}};
    assign div_req.den   = {root_res.root, 2'b00};

    bpb_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .res   (div_res)
    );

    // Floor the signed quotient and add the 0.5 offset
    assign q_mag  = Q_W'(div_res.quo);
    assign q_val  = diff_neg ? (Q_W'(0) - q_mag - Q_W'(div_res.rem_nz)) : q_mag;
    assign pb_sum = q_val + Q_W'(HALF);

    assign fill_base = s_tuser ? '0 : fill_reg;
    assign n_clamp   = (32'(wl_reg) > WINDOW_MAX) ? CNT_W'(WINDOW_MAX) : CNT_W'(wl_reg);
    assign n_close   = NC_W'(n_reg) * NC_W'(close_reg);

    always_comb
    begin
        state_next     = state_reg;
        slot_next      = slot_reg;
        fill_next      = fill_reg;
        close_next     = close_reg;
        n_next         = n_reg;
        rd_ptr_next    = rd_ptr_reg;
        issue_next     = issue_reg;
        v1_next        = issue_en;
        v2_next        = v1_reg;
        sq_next        = sq_reg;
        sum_next       = sum_reg;
        sumsq_next     = sumsq_reg;
        mcand_next     = mcand_reg;
        mplier_next    = mplier_reg;
        nq_next        = nq_reg;
        ss_next        = ss_reg;
        diff_next      = diff_reg;
        res_pb_next    = res_pb_reg;
        res_full_next  = res_full_reg;
        res_flat_next  = res_flat_reg;
        res_clip_next  = res_clip_reg;
        out_pb_next    = out_pb_reg;
        out_full_next  = out_full_reg;
        out_flat_next  = out_flat_reg;
        out_clip_next  = out_clip_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    slot_next = (slot_reg == SLOT_W'(WINDOW_MAX - 1)) ?
                                '0 : slot_reg + SLOT_W'(1);
                    fill_next = (fill_base < CNT_W'(WINDOW_MAX)) ?
                                fill_base + CNT_W'(1) : fill_base;
                    close_next    = s_tdata[PRICE_W-1:0];
                    n_next        = n_clamp;
                    rd_ptr_next   = slot_reg;
                    issue_next    = '0;
                    sum_next      = '0;
                    sumsq_next    = '0;
                    res_pb_next   = PB_W'(HALF);
                    res_full_next = 1'b0;
                    res_flat_next = 1'b0;
                    res_clip_next = 1'b0;
                    if ((n_clamp != '0) && (fill_next >= n_clamp))
                    begin
                        res_full_next = 1'b1;
                        state_next    = ST_ACC;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end

            ST_ACC:
            begin
                if (issue_en)
                begin
                    issue_next  = issue_reg + CNT_W'(1);
                    rd_ptr_next = (rd_ptr_reg == '0) ?
                                  SLOT_W'(WINDOW_MAX - 1) : rd_ptr_reg - SLOT_W'(1);
                end
                // Square on the read data, accumulate one stage later
                if (v1_reg)
                begin
                    sq_next  = SQ_W'(ring_rdata) * SQ_W'(ring_rdata);
                    sum_next = sum_reg + SUM_W'(ring_rdata);
                end
                if (v2_reg)
                begin
                    sumsq_next = sumsq_reg + SUMSQ_W'(sq_reg);
                end
                if ((issue_reg == n_reg) && !v1_reg && !v2_reg)
                begin
                    mcand_next  = D_W'(sumsq_reg);
                    mplier_next = n_reg;
                    nq_next     = '0;
                    state_next  = ST_MUL;
                end
            end

            ST_MUL:
            begin
                // N*sumsq by shift-add; S*S and N*close - S alongside
                ss_next   = D_W'(sum_reg) * D_W'(sum_reg);
                diff_next = DIFF_W'(n_close) - DIFF_W'(sum_reg);
                if (mplier_reg == '0)
                begin
                    state_next = ST_DIFF;
                end
                else
                begin
                    if (mplier_reg[0])
                    begin
                        nq_next = nq_reg + mcand_reg;
                    end
                    mcand_next  = mcand_reg << 1;
                    mplier_next = mplier_reg >> 1;
                end
            end

            ST_DIFF:
            begin
                state_next = ST_ROOT;
            end

            ST_ROOT:
            begin
                if (root_res.done)
                begin
                    if (root_res.root == '0)
                    begin
                        res_flat_next = 1'b1;
                        state_next    = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_DIV;
                    end
                end
            end

            ST_DIV:
            begin
                if (div_res.done)
                begin
                    if (div_res.ovf)
                    begin
                        res_clip_next = 1'b1;
                        res_pb_next   = diff_neg ? PB_W'(PB_MIN) : PB_W'(PB_MAX);
                    end
                    else if ($signed(pb_sum) > $signed(Q_W'(PB_MAX)))
                    begin
                        res_clip_next = 1'b1;
                        res_pb_next   = PB_W'(PB_MAX);
                    end
                    else if ($signed(pb_sum) < $signed(Q_W'(PB_MIN)))
                    begin
                        res_clip_next = 1'b1;
                        res_pb_next   = PB_W'(PB_MIN);
                    end
                    else
                    begin
                        res_pb_next = pb_sum[PB_W-1:0];
                    end
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                // Hold until the output register is free
                if (out_load)
                begin
                    out_pb_next    = res_pb_reg;
                    out_full_next  = res_full_reg;
                    out_flat_next  = res_flat_reg;
                    out_clip_next  = res_clip_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wl_reg        <= WINDOW_RESET;
            slot_reg      <= '0;
            fill_reg      <= '0;
            issue_reg     <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            mplier_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            slot_reg      <= slot_next;
            fill_reg      <= fill_next;
            issue_reg     <= issue_next;
            v1_reg        <= v1_next;
            v2_reg        <= v2_next;
            mplier_reg    <= mplier_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                wl_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        close_reg    <= close_next;
        n_reg        <= n_next;
        rd_ptr_reg   <= rd_ptr_next;
        sq_reg       <= sq_next;
        sum_reg      <= sum_next;
        sumsq_reg    <= sumsq_next;
        mcand_reg    <= mcand_next;
        nq_reg       <= nq_next;
        ss_reg       <= ss_next;
        diff_reg     <= diff_next;
        res_pb_reg   <= res_pb_next;
        res_full_reg <= res_full_next;
        res_flat_reg <= res_flat_next;
        res_clip_reg <= res_clip_next;
        out_pb_reg   <= out_pb_next;
        out_full_reg <= out_full_next;
        out_flat_reg <= out_flat_next;
        out_clip_reg <= out_clip_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = TDATA_OUT_W'(out_pb_reg);
    assign m_tuser  = {out_clip_reg, out_flat_reg, out_full_reg};

endmodule

`default_nettype wire

### tb/bollinger_percent_b_tb.sv
`timescale 1ns / 100ps

module bollinger_percent_b_tb;
    import bpb_pkg::*;

    // Bound the run well above the slowest legal pass: about 450 items, plus
    // sender gaps and receiver stalls.
    localparam int CYCLE_LIMIT = 400000;
    // Allow this many quiet cycles at the end for a stray late result.
    localparam int TAIL_CYCLES = 200;

    typedef enum int {IDLE_NONE, IDLE_SRC, IDLE_SINK, IDLE_BOTH} idle_mode_t;

    typedef logic [SLOT_W-1:0] slot_t;

    // One result item split into its fields.
    typedef struct {
        logic [PB_W-1:0] percent_b;
        logic            window_full;
        logic            flat_window;
        logic            clipped;
    } band_result_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [TDATA_IN_W-1:0]  s_tdata;    // [23:0] close_price
    logic                   s_tuser;    // [0] start_series
    logic                   m_tvalid;
    logic                   m_tready;
    logic [TDATA_OUT_W-1:0] m_tdata;    // [19:0] percent_b, rest zero
    logic [2:0]             m_tuser;    // [0] window_full, [1] flat_window, [2] clipped
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_W-1:0]       cfg_data;   // window_length

    // Shadow state of the band calculator.
    logic [PRICE_W-1:0] price_hist [WINDOW_MAX];
    slot_t              hist_slot;
    int unsigned        series_fill;
    logic [CFG_W-1:0]   win_setting;

    // Expected result items, oldest first.
    band_result_t band_pending[$];

    int src_idle_pct;
    int sink_stall_pct;
    int error_count;
    int prices_sent;
    int results_seen;
    int full_seen;
    int flat_seen;
    int settings_written;
    int cycle_count;

    bollinger_percent_b u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    always #5 clk = ~clk;

    // Toggle the receiver's ready at the falling edge; stall rate per phase.
    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // Integer square root, floor, by the classic bit-pair method.
    function automatic longint unsigned isqrt_floor(input longint unsigned value);
        longint unsigned root;
        longint unsigned probe;
        longint unsigned rest;
        root  = 0;
        rest  = value;
        probe = 64'h1 << 62;
        while (probe > rest)
            probe = probe >> 2;
        while (probe != 0)
        begin
            if (rest >= root + probe)
            begin
                rest = rest - (root + probe);
                root = (root >> 1) + probe;
            end
            else
            begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        return root;
    endfunction

    // Advance the shadow state by one price and return the %B item it yields.
    function automatic band_result_t predict_band(input logic [PRICE_W-1:0] close,
                                                  input logic start);
        band_result_t    res;
        int unsigned     span;
        int unsigned     j;
        slot_t           idx;
        longint unsigned sum_p;
        longint unsigned sum_sq;
        longint unsigned spread;
        longint unsigned root;
        longint unsigned p;
        longint          num;
        longint          den;
        longint          quo;
        longint          pb;

        span = (win_setting > WINDOW_MAX) ? WINDOW_MAX : win_setting;
        pb   = HALF;
        res.window_full = 1'b0;
        res.flat_window = 1'b0;
        res.clipped     = 1'b0;

        // A new series forgets every price held so far.
        if (start)
            series_fill = 0;

        price_hist[hist_slot] = close;
        hist_slot = hist_slot + slot_t'(1);
        if (series_fill < WINDOW_MAX)
            series_fill++;

        if (span > 0 && series_fill >= span)
        begin
            res.window_full = 1'b1;
            sum_p  = 0;
            sum_sq = 0;
            for (j = 0; j < span; j++)
            begin
                idx    = hist_slot - slot_t'(j + 1);
                p      = longint'(price_hist[idx]);
                sum_p  = sum_p + p;
                sum_sq = sum_sq + p * p;
            end
            spread = longint'(span) * sum_sq - sum_p * sum_p;
            root   = isqrt_floor(spread);
            if (root == 0)
            begin
                // All prices equal: no band, hold the midpoint.
                res.flat_window = 1'b1;
            end
            else
            begin
                num = (longint'(span) * longint'(close) - longint'(sum_p))
                      * (longint'(1) << FRAC_BITS);
                den = longint'(4 * root);
                quo = num / den;
                // Round toward minus infinity, not toward zero.
                if ((num % den) != 0 && num < 0)
                    quo = quo - 1;
                if (quo > longint'(PB_MAX - HALF))
                begin
                    pb = PB_MAX;
                    res.clipped = 1'b1;
                end
                else if (quo < longint'(PB_MIN - HALF))
                begin
                    pb = PB_MIN;
                    res.clipped = 1'b1;
                end
                else
                begin
                    pb = pb + quo;
                end
            end
        end
        res.percent_b = PB_W'(pb);
        return res;
    endfunction

    task automatic check_field(input string label, input longint want, input longint got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
            error_count++;
        end
    endtask

    // Watch all three channels at the rising edge: compare each result item,
    // predict each accepted price, track each register write.
    always @(posedge clk)
    begin : monitor
        band_result_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                if (band_pending.size() == 0)
                begin
                    $display("%0t: result with nothing expected, actual percent_b %0d flags %b",
                             $time, $signed(m_tdata[PB_W-1:0]), m_tuser);
                    error_count++;
                end
                else
                begin
                    want = band_pending.pop_front();
                    check_field("percent_b", $signed(want.percent_b),
                                $signed(m_tdata[PB_W-1:0]));
                    check_field("window_full", want.window_full, m_tuser[0]);
                    check_field("flat_window", want.flat_window, m_tuser[1]);
                    check_field("clipped", want.clipped, m_tuser[2]);
                end
            end
            if (s_tvalid && s_tready)
            begin
                want = predict_band(s_tdata[PRICE_W-1:0], s_tuser);
                band_pending = {band_pending, want};
                prices_sent++;
                if (want.window_full)
                    full_seen++;
                if (want.flat_window)
                    flat_seen++;
            end
            if (cfg_valid && cfg_ready)
            begin
                win_setting = cfg_data;
                settings_written++;
            end
        end
    end

    task automatic set_idle(input idle_mode_t mode);
        src_idle_pct   = (mode == IDLE_SRC)  ? 66 : (mode == IDLE_BOTH) ? 19 : 0;
        sink_stall_pct = (mode == IDLE_SINK) ? 66 : (mode == IDLE_BOTH) ? 19 : 0;
    endtask

    // Offer one price; hold it until the block takes it. Leave tvalid high on
    // return so that back-to-back items need no extra edge.
    task automatic send_price(input logic [PRICE_W-1:0] price, input logic start);
        @(negedge clk);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= TDATA_IN_W'(price);
        s_tuser  <= start;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // Drop tvalid and hold off until every expected item has come back.
    task automatic wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (band_pending.size() != 0)
            @(negedge clk);
    endtask

    // Change the window only with nothing in flight.
    task automatic write_window(input logic [CFG_W-1:0] length);
        wait_drained();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= length;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Reset window of 20 is never reached by two prices.
    task automatic test_unfilled_default();
        set_idle(IDLE_NONE);
        send_price(24'd0, 1'b1);
        send_price(24'hFFFFFF, 1'b0);
    endtask

    // A zero window never fills, whatever the prices.
    task automatic test_zero_window();
        write_window(CFG_W'(0));
        send_price(24'hFFFFFF, 1'b1);
        send_price(24'd12345, 1'b0);
    endtask

    // One price alone has no spread: full and flat on every item.
    task automatic test_single_price_window();
        write_window(CFG_W'(1));
        send_price(24'h800000, 1'b1);
        send_price(24'h7FFFFF, 1'b0);
    endtask

    // Two-price window: flat, both extremes, then a restart mid-stream.
    task automatic test_pair_window();
        write_window(CFG_W'(2));
        send_price(24'd0, 1'b1);
        send_price(24'd0, 1'b0);
        send_price(24'hFFFFFF, 1'b0);
        send_price(24'd0, 1'b0);
        send_price(24'd5, 1'b1);
        send_price(24'd6, 1'b0);
    endtask

    // Lone spike above a flat floor, then a drop back.
    task automatic test_spike();
        write_window(CFG_W'(3));
        send_price(24'd0, 1'b1);
        send_price(24'd0, 1'b0);
        send_price(24'hFFFFFF, 1'b0);
        send_price(24'd1, 1'b0);
    endtask

    // Pick the next price of a series in the given style.
    function automatic logic [PRICE_W-1:0] next_price(input int style, input int base);
        int level;
        case (style)
            0: return PRICE_W'($urandom);
            1:
            begin
                level = base + $urandom_range(0, 511) - 256;
                if (level < 0)
                    level = 0;
                if (level > 24'hFFFFFF)
                    level = 24'hFFFFFF;
                return PRICE_W'(level);
            end
            2: return PRICE_W'(base);
            3: return $urandom_range(0, 1) ? 24'hFFFFFF : 24'd0;
            default: return PRICE_W'($urandom_range(0, 15));
        endcase
    endfunction

    // Mostly whole series long enough to fill the window, with a few restarts
    // that break a series off early.
    task automatic test_random_series(input logic [CFG_W-1:0] length,
                                      input idle_mode_t mode, input int items);
        int sent;
        int run_len;
        int style;
        int base;
        int k;
        int span;
        logic start;
        write_window(length);
        set_idle(mode);
        span = (length > WINDOW_MAX) ? WINDOW_MAX : int'(length);
        sent = 0;
        while (sent < items)
        begin
            run_len = span + $urandom_range(1, 24);
            style   = $urandom_range(0, 4);
            base    = $urandom_range(0, 24'hFFFFFF);
            for (k = 0; k < run_len && sent < items; k++)
            begin
                start = (k == 0) || ($urandom_range(0, 39) == 0);
                send_price(next_price(style, base), start);
                sent++;
                // Halfway through, let the pipeline run dry before going on.
                if (sent == items / 2)
                    wait_drained();
            end
        end
    endtask

    // Watchdog: stop a hung run.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("** bollinger_percent_b: FAILED **");
        $finish;
    end

    initial
    begin
        clk              = 1'b0;
        rst_n            = 1'b0;
        s_tvalid         = 1'b0;
        s_tdata          = '0;
        s_tuser          = 1'b0;
        m_tready         = 1'b0;
        cfg_valid        = 1'b0;
        cfg_data         = '0;
        hist_slot        = '0;
        series_fill      = 0;
        win_setting      = WINDOW_RESET;
        error_count      = 0;
        prices_sent      = 0;
        results_seen     = 0;
        full_seen        = 0;
        flat_seen        = 0;
        settings_written = 0;
        set_idle(IDLE_NONE);

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        test_unfilled_default();
        test_zero_window();
        test_single_price_window();
        test_pair_window();
        test_spike();

        // Sweep window sizes and idle patterns, extremes included: the full
        // 64, the all-ones register value above it, zero and one.
        test_random_series(CFG_W'(20), IDLE_NONE, 50);
        test_random_series(CFG_W'(64), IDLE_SRC, 100);
        test_random_series(CFG_W'(3), IDLE_SINK, 40);
        test_random_series(CFG_W'(127), IDLE_BOTH, 100);
        test_random_series(CFG_W'(0), IDLE_NONE, 20);
        test_random_series(CFG_W'(1), IDLE_SRC, 20);
        test_random_series(CFG_W'($urandom_range(4, 63)), IDLE_SINK, 50);
        test_random_series(CFG_W'(2), IDLE_BOTH, 50);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (band_pending.size() != 0)
        begin
            $display("%0t: %0d expected items never arrived", $time, band_pending.size());
            error_count++;
        end

        $display("Sent %0d prices over %0d window settings, checked %0d results",
                 prices_sent, settings_written, results_seen);
        $display("%0d results had a full window, %0d of them flat; %0d mismatches",
                 full_seen, flat_seen, error_count);
        if (error_count == 0)
            $display("** bollinger_percent_b: PASSED **");
        else
            $display("** bollinger_percent_b: FAILED **");
        $finish;
    end

endmodule

### files.f
rtl/bpb_pkg.sv
rtl/bpb_ring.sv
rtl/bpb_isqrt.sv
rtl/bpb_div.sv
rtl/bollinger_percent_b.sv
tb/bollinger_percent_b_tb.sv
